>>> sv/fsc_pkg.sv
// ----------------------------------------------------------------------------
// Flash image section checker package
// Shared types, phase codes, event codes and CRC byte update functions.
// ----------------------------------------------------------------------------
package fsc_pkg;

  // Brace characters that frame the text header
  localparam logic [7:0] OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CLOSE_BRACE = 8'h7D;

  // Field sizes in bytes
  localparam logic [31:0] ADDR_BYTES = 32'd4;
  localparam logic [31:0] LEN_BYTES  = 32'd4;
  localparam logic [31:0] CRC_BYTES  = 32'd2;

  // CRC constants
  localparam logic [31:0] CRC32_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC32_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC32_XOROUT = 32'hFFFF_FFFF;
  localparam logic [15:0] CRC16_POLY  = 16'h1021;
  localparam logic [15:0] CRC16_INIT  = 16'hFFFF;

  // Default depth of the result queue (at least two)
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ADDR   = 3'd1,
    PH_LEN    = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_SECTION_HEADER = 2'd0,
    EV_SECTION_DONE   = 2'd1,
    EV_FILE_DONE      = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } byte_req_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [31:0] section_address;
    logic [31:0] section_length;
    logic        section_crc_ok;
    logic [31:0] file_crc_value;
    logic        file_crc_ok;
    logic        truncated;
    logic        last_result;
  } event_req_t;

  // Reflected CRC-32 update by one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // MSB-first CRC-16 update by one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> sv/fsc_parser.sv
// ----------------------------------------------------------------------------
// Flash image section parser
// Holds the framing state and the running CRCs; turns one accepted byte into
// up to two result events in the same cycle.
// ----------------------------------------------------------------------------
module fsc_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  fsc_pkg::byte_req_t  byte_req,
  input  logic [31:0]         expected_file_crc,
  output fsc_pkg::event_req_t res_first,
  output fsc_pkg::event_req_t res_second,
  output logic [1:0]          res_count
);

  // State registers
  fsc_pkg::phase_t phase;
  logic [15:0]     brace_depth;
  logic [31:0]     field_byte_count;
  logic [31:0]     address_shift;
  logic [31:0]     length_shift;
  logic [15:0]     section_crc_running;
  logic [15:0]     stored_section_crc;
  logic [31:0]     file_crc_running;

  fsc_pkg::phase_t phase_next;
  logic [15:0]     brace_depth_next;
  logic [31:0]     field_byte_count_next;
  logic [31:0]     address_shift_next;
  logic [31:0]     length_shift_next;
  logic [15:0]     section_crc_running_next;
  logic [15:0]     stored_section_crc_next;
  logic [31:0]     file_crc_running_next;

  // Values after the byte step, before the end-of-file clear
  fsc_pkg::phase_t phase_step;
  logic [31:0]     count_step;
  logic [31:0]     count_inc;
  logic [15:0]     depth_dec;
  logic            sec_event;
  logic [1:0]      sec_kind;
  logic            sec_crc_ok;
  logic [7:0]      b;
  logic            eof;
  logic [31:0]     file_crc_final;

  assign b         = byte_req.data_byte;
  assign eof       = byte_req.end_of_file;
  assign count_inc = field_byte_count + 32'd1;
  assign depth_dec = brace_depth - 16'd1;

  // Advance the framing state by one byte
  always_comb begin
    phase_step               = phase;
    count_step               = field_byte_count;
    brace_depth_next         = brace_depth;
    address_shift_next       = address_shift;
    length_shift_next        = length_shift;
    section_crc_running_next = section_crc_running;
    stored_section_crc_next  = stored_section_crc;
    file_crc_running_next    = file_crc_running;
    sec_event                = 1'b0;
    sec_kind                 = fsc_pkg::EV_SECTION_HEADER;
    sec_crc_ok               = 1'b0;

    if (phase != fsc_pkg::PH_HEADER) begin
      file_crc_running_next = fsc_pkg::crc32_byte(file_crc_running, b);
    end

    case (phase)
      fsc_pkg::PH_ADDR: begin
        address_shift_next = {address_shift[23:0], b};
        count_step         = count_inc;
        if (count_inc == fsc_pkg::ADDR_BYTES) begin
          phase_step = fsc_pkg::PH_LEN;
          count_step = 32'd0;
        end
      end
      fsc_pkg::PH_LEN: begin
        length_shift_next = {length_shift[23:0], b};
        count_step        = count_inc;
        if (count_inc == fsc_pkg::LEN_BYTES) begin
          sec_event                = 1'b1;
          sec_kind                 = fsc_pkg::EV_SECTION_HEADER;
          section_crc_running_next = fsc_pkg::CRC16_INIT;
          stored_section_crc_next  = 16'd0;
          count_step               = 32'd0;
          phase_step = ({length_shift[23:0], b} == 32'd0) ? fsc_pkg::PH_CRC
                                                            : fsc_pkg::PH_DATA;
        end
      end
      fsc_pkg::PH_DATA: begin
        section_crc_running_next = fsc_pkg::crc16_byte(section_crc_running, b);
        count_step               = count_inc;
        if (count_inc == length_shift) begin
          phase_step = fsc_pkg::PH_CRC;
          count_step = 32'd0;
        end
      end
      fsc_pkg::PH_CRC: begin
        stored_section_crc_next = {stored_section_crc[7:0], b};
        count_step              = count_inc;
        if (count_inc == fsc_pkg::CRC_BYTES) begin
          sec_event  = 1'b1;
          sec_kind   = fsc_pkg::EV_SECTION_DONE;
          sec_crc_ok = ({stored_section_crc[7:0], b} == section_crc_running);
          phase_step = fsc_pkg::PH_ADDR;
          count_step = 32'd0;
        end
      end
      default: begin
        if (b == fsc_pkg::OPEN_BRACE) begin
          brace_depth_next = brace_depth + 16'd1;
        end else if (b == fsc_pkg::CLOSE_BRACE) begin
          brace_depth_next = depth_dec;
          if (depth_dec == 16'd0) begin
            phase_step = fsc_pkg::PH_ADDR;
            count_step = 32'd0;
          end
        end
      end
    endcase
  end

  assign file_crc_final = file_crc_running_next ^ fsc_pkg::CRC32_XOROUT;

  // Build the result events for this byte
  always_comb begin
    fsc_pkg::event_req_t sec_res;
    fsc_pkg::event_req_t file_res;

    sec_res.event_kind      = sec_kind;
    sec_res.section_address = address_shift_next;
    sec_res.section_length  = length_shift_next;
    sec_res.section_crc_ok  = sec_crc_ok;
    sec_res.file_crc_value  = 32'd0;
    sec_res.file_crc_ok     = 1'b0;
    sec_res.truncated       = 1'b0;
    sec_res.last_result     = !eof;

    file_res.event_kind      = fsc_pkg::EV_FILE_DONE;
    file_res.section_address = address_shift_next;
    file_res.section_length  = length_shift_next;
    file_res.section_crc_ok  = 1'b0;
    file_res.file_crc_value  = file_crc_final;
    file_res.file_crc_ok     = (file_crc_final == expected_file_crc);
    file_res.truncated       = !((phase_step == fsc_pkg::PH_ADDR) && (count_step == 32'd0));
    file_res.last_result     = 1'b1;

    res_first  = sec_event ? sec_res : file_res;
    res_second = file_res;
    res_count  = {1'b0, sec_event} + {1'b0, eof};
  end

  // Drop back to the start of a file after its last byte
  always_comb begin
    phase_next            = phase_step;
    field_byte_count_next = count_step;
    if (eof) begin
      phase_next            = fsc_pkg::PH_HEADER;
      field_byte_count_next = 32'd0;
    end
  end

  // Update state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= fsc_pkg::PH_HEADER;
      brace_depth         <= 16'd0;
      field_byte_count    <= 32'd0;
      address_shift       <= 32'd0;
      length_shift        <= 32'd0;
      section_crc_running <= fsc_pkg::CRC16_INIT;
      stored_section_crc  <= 16'd0;
      file_crc_running    <= fsc_pkg::CRC32_INIT;
    end else if (accept) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      if (eof) begin
        brace_depth         <= 16'd0;
        address_shift       <= 32'd0;
        length_shift        <= 32'd0;
        section_crc_running <= fsc_pkg::CRC16_INIT;
        stored_section_crc  <= 16'd0;
        file_crc_running    <= fsc_pkg::CRC32_INIT;
      end else begin
        brace_depth         <= brace_depth_next;
        address_shift       <= address_shift_next;
        length_shift        <= length_shift_next;
        section_crc_running <= section_crc_running_next;
        stored_section_crc  <= stored_section_crc_next;
        file_crc_running    <= file_crc_running_next;
      end
    end
  end

endmodule

>>> sv/fsc_event_queue.sv
// ----------------------------------------------------------------------------
// Flash image section checker result queue
// Small register queue that takes up to two events a cycle and hands out one.
// ----------------------------------------------------------------------------
module fsc_event_queue #(
  parameter int DEPTH = fsc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_count,
  input  fsc_pkg::event_req_t push_first,
  input  fsc_pkg::event_req_t push_second,
  input  logic                pop,
  output fsc_pkg::event_req_t head,
  output logic                not_empty,
  output logic                near_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] TWO_FREE  = CW'(DEPTH - 2);

  fsc_pkg::event_req_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [AW-1:0] wr_ptr_plus1;
  logic [AW-1:0] wr_ptr_plus2;
  logic [AW-1:0] rd_ptr_next;
  logic [CW-1:0] count_next;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  assign wr_ptr_plus1 = wrap_inc(wr_ptr);
  assign wr_ptr_plus2 = wrap_inc(wr_ptr_plus1);
  assign rd_ptr_next  = pop ? wrap_inc(rd_ptr) : rd_ptr;
  assign count_next   = count + CW'(push_count) - CW'(pop);

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign near_full = (count > TWO_FREE);

  // Hold the queued events
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr_plus1] <= push_second;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
      case (push_count)
        2'd1:    wr_ptr <= wr_ptr_plus1;
        2'd2:    wr_ptr <= wr_ptr_plus2;
        default: wr_ptr <= wr_ptr;
      endcase
    end
  end

endmodule

>>> sv/flash_image_section_checker_unit.sv
// ----------------------------------------------------------------------------
// Flash image section checker
// Parses a firmware image byte stream and reports section and file events.
// ----------------------------------------------------------------------------
// The block takes one image byte per clock cycle when not stalled, parsing
// the text header, each binary section and the running CRC-16 and CRC-32
// in combinational logic that updates its state registers. A byte yields
// zero, one or two events; they enter a queue of QUEUE_DEPTH entries and
// appear on the event channel from the next cycle on, in order. The byte
// channel stalls only while fewer than two queue entries are free, so with
// the event channel draining the block sustains one byte per cycle. Write
// expected_file_crc only while no file is in flight.
module flash_image_section_checker_unit #(
  parameter int QUEUE_DEPTH = fsc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  fsc_pkg::byte_req_t  byte_req,
  output logic                event_valid,
  input  logic                event_stall,
  output fsc_pkg::event_req_t event_req
);

  logic [31:0]         expected_crc;
  logic                accept;
  logic                pop;
  logic                near_full;
  fsc_pkg::event_req_t res_first;
  fsc_pkg::event_req_t res_second;
  logic [1:0]          res_count;
  logic [1:0]          push_count;

  // Hold the configured file CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_crc <= 32'd0;
    end else if (cfg_wr_en) begin
      expected_crc <= cfg_wr_data;
    end
  end

  assign byte_stall = near_full;
  assign accept     = byte_valid & !byte_stall;
  assign pop        = event_valid & !event_stall;
  assign push_count = accept ? res_count : 2'd0;

  fsc_parser u_parser (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .byte_req          (byte_req),
    .expected_file_crc (expected_crc),
    .res_first         (res_first),
    .res_second        (res_second),
    .res_count         (res_count)
  );

  fsc_event_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_first  (res_first),
    .push_second (res_second),
    .pop         (pop),
    .head        (event_req),
    .not_empty   (event_valid),
    .near_full   (near_full)
  );

endmodule
